// ----- design/lse_pkg.sv -----
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LIFO stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W   = 7;
    localparam int WORD_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
    localparam logic [CAP_W-1:0] CAP_DEPTH = CAP_W'(DEPTH);
    localparam logic [WORD_W-1:0] FAIL_WORD = '1;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_DISPLAY = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_read;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_read;
        logic more;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/lse_ctrl.sv -----
// ----------------------------------------------------------------------------
// lse_ctrl
// Controller: sequences accept, memory read and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire lse_pkg::t_dp_stat i_stat,
    output lse_pkg::t_dp_cmd       o_cmd
);
    import lse_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign in_ready = (r_state == S_IDLE) ||
                      ((r_state == S_OUT) && i_out_ready && !i_stat.more);
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = accept;
        o_cmd.load_read = 1'b0;
        o_cmd.step      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_stat.needs_read ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (accept) begin
                    n_state = i_stat.needs_read ? S_READ : S_OUT;
                end else if (i_out_ready) begin
                    if (i_stat.more) begin
                        o_cmd.step = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = (r_state == S_OUT);

endmodule

`default_nettype wire

// ----- design/lse_datapath.sv -----
// ----------------------------------------------------------------------------
// lse_datapath
// Entry memory, count, capacity register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lse_pkg::t_dp_cmd              i_cmd,
    output lse_pkg::t_dp_stat                  o_stat,
    input  wire logic [1:0]                    i_action,
    input  wire logic [lse_pkg::WORD_W-1:0]    i_push_value,
    input  wire logic                          i_cfg_valid,
    input  wire logic [lse_pkg::CAP_W-1:0]     i_cfg_data,
    output logic [lse_pkg::WORD_W-1:0]         o_word_out,
    output logic [1:0]                         o_status,
    output logic                               o_run_last,
    output logic                               o_is_empty,
    output logic                               o_is_full
);
    import lse_pkg::*;

    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [WORD_W-1:0]  r_rd_data;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [CAP_W-1:0]   r_cap;
    t_action            r_action;
    logic [ADDR_W-1:0]  r_idx;

    logic [WORD_W-1:0]  r_word;
    t_status            r_status;
    logic               r_last;
    logic               r_empty;
    logic               r_full;

    t_action            act;
    logic [CAP_W-1:0]   eff_cap;
    logic               full_now;
    logic               nonempty;
    logic [ADDR_W-1:0]  top_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               do_write;
    logic               load_direct;
    logic [WORD_W-1:0]  n_word;
    t_status            n_status;

    assign act      = t_action'(i_action);
    assign nonempty = (r_count != '0);
    assign top_addr = ADDR_W'(r_count - COUNT_W'(1));

    always_comb begin
        priority if (r_cap == '0) begin
            eff_cap = CAP_W'(1);
        end else if (r_cap > CAP_DEPTH) begin
            eff_cap = CAP_DEPTH;
        end else begin
            eff_cap = r_cap;
        end
    end

    assign full_now = (CAP_W'(r_count) >= eff_cap);

    assign o_stat.needs_read = (act != ACT_PUSH) && nonempty;
    assign o_stat.more       = (r_action == ACT_DISPLAY) && !r_last;

    assign rd_addr     = i_cmd.accept ? top_addr : (r_idx - ADDR_W'(1));
    assign do_write    = i_cmd.accept && (act == ACT_PUSH) && !full_now;
    assign load_direct = i_cmd.accept && !o_stat.needs_read;

    always_comb begin
        n_count  = r_count;
        n_word   = FAIL_WORD;
        n_status = ST_EMPTY;
        if (i_cmd.accept) begin
            unique case (act)
                ACT_PUSH: begin
                    if (full_now) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_count  = r_count + COUNT_W'(1);
                        n_word   = i_push_value;
                        n_status = ST_OK;
                    end
                end
                ACT_POP: begin
                    if (nonempty) begin
                        n_count = r_count - COUNT_W'(1);
                    end
                end
                ACT_PEEK, ACT_DISPLAY: begin
                    n_count = r_count;
                end
                default: n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[top_addr + ADDR_W'(1)] <= i_push_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= act;
            r_idx    <= top_addr;
        end else if (i_cmd.step) begin
            r_idx <= r_idx - ADDR_W'(1);
        end
        if (load_direct) begin
            r_word   <= n_word;
            r_status <= n_status;
            r_last   <= 1'b1;
        end else if (i_cmd.load_read) begin
            r_word   <= r_rd_data;
            r_status <= ST_OK;
            r_last   <= (r_action != ACT_DISPLAY) || (r_idx == '0);
        end
        if (load_direct || i_cmd.load_read) begin
            r_empty <= (n_count == '0);
            r_full  <= (CAP_W'(n_count) >= eff_cap);
        end
    end

    assign o_word_out = r_word;
    assign o_status   = r_status;
    assign o_run_last = r_last;
    assign o_is_empty = r_empty;
    assign o_is_full  = r_full;

endmodule

`default_nettype wire

// ----- design/lifo_stack_engine_top.sv -----
// Push and failed actions load the result register directly at accept; pop
// and peek first go through the registered memory read and state S_READ.
// Display reads its entries one by one through the single memory read port.
// A new item is taken in the cycle the last result of the previous one leaves.
// Synchronous active-low reset empties the stack and sets capacity to 64.
// ----------------------------------------------------------------------------
// lifo_stack_engine_top
// LIFO stack of signed 32-bit words with push, pop, peek and display.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_engine_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_action,
    input  wire logic signed [lse_pkg::WORD_W-1:0] i_push_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [lse_pkg::WORD_W-1:0]  o_word_out,
    output logic [1:0]                         o_status,
    output logic                               o_run_last,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lse_pkg::CAP_W-1:0]     i_cfg_data
);
    import lse_pkg::*;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [WORD_W-1:0] word_out;

    lse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lse_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_word_out   (word_out),
        .o_status     (o_status),
        .o_run_last   (o_run_last),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    assign o_word_out  = word_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lifo_stack_engine_top. A directed table walks empty,
// full and lowered-capacity corners with known results, then phases of random
// push/pop/peek/display traffic run under several capacity settings. Every
// result is checked field by field against a behavioral stack in the bench,
// with bursty input traffic and a stalling output side.
// ----------------------------------------------------------------------------
module tb;
    import lse_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS    = 40;
    localparam int N_ROWS        = 26;

    typedef struct {
        logic [WORD_W-1:0] word;
        t_status           status;
        logic              last;
        logic              empty;
        logic              full;
    } t_stack_result;

    typedef struct {
        logic              is_cfg;
        t_action           act;
        logic [WORD_W-1:0] val;
        logic              typed;
        logic [WORD_W-1:0] t_word;
        t_status           t_stat;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_action;
    logic [WORD_W-1:0] i_push_value;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WORD_W-1:0] o_word_out;
    logic [1:0]        o_status;
    logic              o_run_last;
    logic              o_is_empty;
    logic              o_is_full;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CAP_W-1:0]  i_cfg_data;

    lifo_stack_engine_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_word_out   (o_word_out),
        .o_status     (o_status),
        .o_run_last   (o_run_last),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // bench copy of the stack
    logic [WORD_W-1:0] stack_mem [DEPTH];
    int                stack_count;
    logic [CAP_W-1:0]  cap_reg;
    t_stack_result     expected_results [$];

    int err_count    = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;
    int rx_cycle     = 0;
    int rx_mode      = 0;
    int n_push       = 0;
    int n_pop        = 0;
    int n_peek       = 0;
    int n_disp       = 0;
    int n_overflow   = 0;
    int n_empty_hit  = 0;
    int longest_run  = 0;
    int n_results    = 0;
    int n_cfg        = 0;

    t_stim_row directed_rows [N_ROWS] = '{
        '{1'b0, ACT_POP,     32'h0000_0000, 1'b1, FAIL_WORD,     ST_EMPTY},
        '{1'b0, ACT_PEEK,    32'h0000_0000, 1'b1, FAIL_WORD,     ST_EMPTY},
        '{1'b0, ACT_DISPLAY, 32'h0000_0000, 1'b1, FAIL_WORD,     ST_EMPTY},
        '{1'b0, ACT_PUSH,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{1'b0, ACT_PUSH,    32'h8000_0000, 1'b1, 32'h8000_0000, ST_OK},
        '{1'b0, ACT_PUSH,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{1'b0, ACT_PUSH,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{1'b0, ACT_PEEK,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{1'b0, ACT_DISPLAY, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
        '{1'b0, ACT_POP,     32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{1'b0, ACT_POP,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{1'b1, ACT_PUSH,    32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
        '{1'b0, ACT_PUSH,    32'h1234_5678, 1'b1, FAIL_WORD,     ST_OVERFLOW},
        '{1'b0, ACT_POP,     32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
        '{1'b0, ACT_PEEK,    32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{1'b0, ACT_POP,     32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{1'b0, ACT_PUSH,    32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, ST_OK},
        '{1'b0, ACT_PUSH,    32'h5A5A_5A5A, 1'b1, FAIL_WORD,     ST_OVERFLOW},
        '{1'b1, ACT_PUSH,    32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{1'b0, ACT_PUSH,    32'h0000_0001, 1'b1, FAIL_WORD,     ST_OVERFLOW},
        '{1'b0, ACT_POP,     32'h0000_0000, 1'b1, 32'hA5A5_A5A5, ST_OK},
        '{1'b1, ACT_PUSH,    32'h0000_007F, 1'b0, 32'h0000_0000, ST_OK},
        '{1'b0, ACT_PUSH,    32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, ST_OK},
        '{1'b0, ACT_PUSH,    32'h3C3C_3C3C, 1'b1, 32'h3C3C_3C3C, ST_OK},
        '{1'b0, ACT_DISPLAY, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{1'b1, ACT_PUSH,    32'h0000_0040, 1'b0, 32'h0000_0000, ST_OK}
    };

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic cmp_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    function automatic int usable_cap();
        int c;
        c = int'(cap_reg);
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic t_stack_result mk_result(input logic [WORD_W-1:0] w,
                                                input t_status s, input logic last);
        t_stack_result r;
        r.word   = w;
        r.status = s;
        r.last   = last;
        r.empty  = (stack_count == 0);
        r.full   = (stack_count >= usable_cap());
        return r;
    endfunction

    task automatic predict_action(input t_action act, input logic [WORD_W-1:0] val,
                                  output t_stack_result head);
        t_stack_result run [$];
        case (act)
            ACT_PUSH: n_push++;
            ACT_POP:  n_pop++;
            ACT_PEEK: n_peek++;
            default:  n_disp++;
        endcase
        if (act == ACT_PUSH) begin
            if (stack_count >= usable_cap()) begin
                n_overflow++;
                run.push_back(mk_result(FAIL_WORD, ST_OVERFLOW, 1'b1));
            end else begin
                stack_mem[stack_count] = val;
                stack_count++;
                run.push_back(mk_result(val, ST_OK, 1'b1));
            end
        end else if (stack_count == 0) begin
            n_empty_hit++;
            run.push_back(mk_result(FAIL_WORD, ST_EMPTY, 1'b1));
        end else if (act == ACT_POP) begin
            stack_count--;
            run.push_back(mk_result(stack_mem[stack_count], ST_OK, 1'b1));
        end else if (act == ACT_PEEK) begin
            run.push_back(mk_result(stack_mem[stack_count-1], ST_OK, 1'b1));
        end else begin
            for (int i = stack_count - 1; i >= 0; i--) begin
                run.push_back(mk_result(stack_mem[i], ST_OK, i == 0));
            end
            if (run.size() > longest_run) longest_run = run.size();
        end
        head = run[0];
        foreach (run[i]) expected_results.push_back(run[i]);
    endtask

    task automatic send_item(input t_action act, input logic [WORD_W-1:0] val,
                             output t_stack_result head);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_push_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_action(act, val, head);
    endtask

    // drop valid and let every pending result come out
    task automatic hold_off();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        hold_off();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_reg = v;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(0, 5))
            0:       return CAP_W'(0);
            1:       return CAP_W'($urandom_range(1, 3));
            2:       return CAP_W'($urandom_range(4, 8));
            3:       return CAP_W'($urandom_range(65, 126));
            4:       return CAP_DEPTH;
            default: return CAP_W'($urandom_range(9, 20));
        endcase
    endfunction

    function automatic t_action rand_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return ACT_PUSH;
        if (r < 65) return ACT_POP;
        if (r < 80) return ACT_PEEK;
        return ACT_DISPLAY;
    endfunction

    // well-formed sequence: fill past full, show all, drain past empty
    task automatic fill_and_drain();
        t_stack_result head;
        while (stack_count < usable_cap()) send_item(ACT_PUSH, rand_word(), head);
        send_item(ACT_PUSH, rand_word(), head);
        send_item(ACT_DISPLAY, rand_word(), head);
        while (stack_count > 0) send_item(ACT_POP, rand_word(), head);
        send_item(ACT_POP, rand_word(), head);
    endtask

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 9) < 7);
            2:       i_out_ready <= (rx_cycle % 5 > 1);
            default: i_out_ready <= (rx_cycle % 8 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_stack_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h status %0d",
                                          o_word_out, o_status));
            end else begin
                e = expected_results.pop_front();
                cmp_field("word_out", o_word_out, e.word);
                cmp_field("status", WORD_W'(o_status), WORD_W'(e.status));
                cmp_field("run_last", WORD_W'(o_run_last), WORD_W'(e.last));
                cmp_field("is_empty", WORD_W'(o_is_empty), WORD_W'(e.empty));
                cmp_field("is_full", WORD_W'(o_is_full), WORD_W'(e.full));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[lifo_stack_engine_top] ERROR");
        $finish;
    end

    initial begin
        t_stack_result head;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = ACT_PUSH;
        i_push_value = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = CAP_RESET;
        stack_count  = 0;
        cap_reg      = CAP_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_capacity(directed_rows[i].val[CAP_W-1:0]);
            end else begin
                send_item(directed_rows[i].act, directed_rows[i].val, head);
                if (directed_rows[i].typed && (head.word !== directed_rows[i].t_word ||
                                               head.status != directed_rows[i].t_stat)) begin
                    report_mismatch($sformatf("directed row %0d: predicted %h/%0d vs table",
                                              i, head.word, head.status));
                end
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            write_capacity(pick_capacity());
            for (int k = 0; k < 6; k++) begin
                if (ph == 2 && k == 3) hold_off();
                if (usable_cap() <= 8 && $urandom_range(0, 9) == 0) begin
                    fill_and_drain();
                end else begin
                    send_item(rand_action(), rand_word(), head);
                end
            end
        end

        // deepest case: full store, then capacity pulled under the count
        write_capacity(CAP_W'(100));
        while (stack_count < DEPTH) send_item(ACT_PUSH, rand_word(), head);
        send_item(ACT_PUSH, rand_word(), head);
        send_item(ACT_DISPLAY, rand_word(), head);
        send_item(ACT_PEEK, rand_word(), head);
        write_capacity(CAP_W'(3));
        send_item(ACT_PUSH, rand_word(), head);
        for (int k = 0; k < 6; k++) send_item(rand_action(), rand_word(), head);

        hold_off();
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Covered %0d pushes, %0d pops, %0d peeks, %0d displays; %0d results checked.",
                 n_push, n_pop, n_peek, n_disp, n_results);
        $display("Hit %0d overflows, %0d empty actions, runs up to %0d, %0d cap writes.",
                 n_overflow, n_empty_hit, longest_run, n_cfg);
        if (err_count == 0) begin
            $display("[lifo_stack_engine_top] OK");
        end else begin
            $display("[lifo_stack_engine_top] ERROR");
        end
        $finish;
    end

endmodule
